/* hdl/sbst_pkg.sv */
package sbst_pkg;

  // fixed-point format of all coordinates
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // quotient bits resolved by the divider; a larger quotient is flagged as overflow
  localparam int QUO_W = DATA_W + 1;
  // width of the scaled numerator magnitude
  localparam int NUM_W = DATA_W + 1 + FRAC_BITS;

  // divider depth: operand stage plus one stage per quotient bit
  localparam int DIV_LAT = QUO_W + 1;
  // total depth: divider, saturation, per-axis order, reduction and compare
  localparam int LAT = DIV_LAT + 3;

  localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE    = DATA_W'(1) << FRAC_BITS;

endpackage

/* hdl/sbst_div.sv */
module sbst_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [sbst_pkg::DATA_W:0]     num_i,
  input  logic signed [sbst_pkg::DATA_W-1:0]   den_i,
  output logic signed [sbst_pkg::DATA_W-1:0]   quo_o
);

  localparam int DW = sbst_pkg::DATA_W;
  localparam int QW = sbst_pkg::QUO_W;
  localparam int NW = sbst_pkg::NUM_W;
  localparam int FB = sbst_pkg::FRAC_BITS;

  logic [DW-1:0] rem_q [0:QW];
  logic [DW-1:0] rem_d [0:QW];
  logic [QW-1:0] low_q [0:QW];
  logic [QW-1:0] low_d [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [QW-1:0] quo_d [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic [DW-1:0] den_d [0:QW];
  logic          ovf_q [0:QW];
  logic          ovf_d [0:QW];
  logic          neg_q [0:QW];
  logic          neg_d [0:QW];

  logic [DW:0]   num_mag;
  logic [DW:0]   den_ext;
  logic [NW-1:0] num_scaled;
  logic [DW:0]   trial [1:QW];
  logic          ge    [1:QW];

  always_comb begin
    num_mag    = num_i[DW] ? (DW+1)'(0) - num_i : num_i;
    den_ext    = den_i[DW-1] ? (DW+1)'(0) - {den_i[DW-1], den_i} : {den_i[DW-1], den_i};
    num_scaled = {num_mag, {FB{1'b0}}};
    den_d[0]   = den_ext[DW-1:0];
    rem_d[0]   = {{(DW-FB){1'b0}}, num_scaled[NW-1:QW]};
    low_d[0]   = num_scaled[QW-1:0];
    quo_d[0]   = '0;
    ovf_d[0]   = ({{(DW-FB){1'b0}}, num_scaled[NW-1:QW]} >= den_ext[DW-1:0]);
    neg_d[0]   = num_i[DW] ^ den_i[DW-1];
    // one restoring step per stage, each stage working on the registered state of the stage before
    for (int i = 1; i <= QW; i++) begin
      trial[i] = {rem_q[i-1], low_q[i-1][QW-1]};
      ge[i]    = trial[i] >= {1'b0, den_q[i-1]};
      rem_d[i] = ge[i] ? DW'(trial[i] - {1'b0, den_q[i-1]}) : trial[i][DW-1:0];
      low_d[i] = low_q[i-1] << 1;
      quo_d[i] = {quo_q[i-1][QW-2:0], ge[i]};
      den_d[i] = den_q[i-1];
      ovf_d[i] = ovf_q[i-1];
      neg_d[i] = neg_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= QW; i++) begin
        rem_q[i] <= rem_d[i];
        low_q[i] <= low_d[i];
        quo_q[i] <= quo_d[i];
        den_q[i] <= den_d[i];
        ovf_q[i] <= ovf_d[i];
        neg_q[i] <= neg_d[i];
      end
    end
  end

  // saturate the magnitude quotient into the signed result range
  always_comb begin
    if (!neg_q[QW]) begin
      if (ovf_q[QW] || quo_q[QW][QW-1] || quo_q[QW][DW-1]) quo_o = sbst_pkg::SAT_HI;
      else quo_o = quo_q[QW][DW-1:0];
    end else begin
      if (ovf_q[QW] || quo_q[QW][QW-1] || (quo_q[QW][DW-1] && (quo_q[QW][DW-2:0] != '0)))
        quo_o = sbst_pkg::SAT_LO;
      else quo_o = DW'(0) - quo_q[QW][DW-1:0];
    end
  end

endmodule

/* hdl/segment_box_slab_test.sv */
// Slab test of a segment (start + t*dir, t in [0,1]) against an axis-aligned box, all in
// signed Q16.16. Fully pipelined: one request is accepted every cycle while the output is
// not stalled. The depth is set by six bit-per-stage restoring dividers (33 quotient
// stages plus an operand stage) followed by saturation, per-axis ordering and the
// entry/exit compare. A stall on a valid output freezes the whole pipeline and is
// passed back on stall_o.
module segment_box_slab_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               hit_o
);

  localparam int DW  = sbst_pkg::DATA_W;
  localparam int DL  = sbst_pkg::DIV_LAT;
  localparam int LAT = sbst_pkg::LAT;

  logic           adv;
  logic [LAT-1:0] vld_q;

  logic signed [DW-1:0] lo_e [3];
  logic signed [DW-1:0] hi_e [3];
  logic signed [DW-1:0] org  [3];
  logic signed [DW-1:0] dir  [3];
  logic signed [DW:0]   num_a [3];
  logic signed [DW:0]   num_b [3];
  logic signed [DW-1:0] quo_a [3];
  logic signed [DW-1:0] quo_b [3];

  logic [2:0] zero_d;
  logic       miss_d;
  logic [2:0] zero_q [0:DL-1];
  logic       miss_q [0:DL-1];

  // post-divider stages
  logic signed [DW-1:0] sa_q [3];
  logic signed [DW-1:0] sb_q [3];
  logic [2:0]           z1_q;
  logic                 m1_q;
  logic signed [DW-1:0] en_q [3];
  logic signed [DW-1:0] lv_q [3];
  logic                 m2_q;
  logic signed [DW-1:0] entry;
  logic signed [DW-1:0] exitv;
  logic                 hit_q;

  assign adv     = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[LAT-1];
  assign hit_o   = hit_q;

  always_comb begin
    lo_e = '{box_min_x_i, box_min_y_i, box_min_z_i};
    hi_e = '{box_max_x_i, box_max_y_i, box_max_z_i};
    org  = '{start_x_i, start_y_i, start_z_i};
    dir  = '{dir_x_i, dir_y_i, dir_z_i};
    miss_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      num_a[a]  = {lo_e[a][DW-1], lo_e[a]} - {org[a][DW-1], org[a]};
      num_b[a]  = {hi_e[a][DW-1], hi_e[a]} - {org[a][DW-1], org[a]};
      zero_d[a] = (dir[a] == '0);
      // a parallel axis misses unless the origin lies between the box edges
      if (zero_d[a] && !((org[a] >= lo_e[a] && org[a] <= hi_e[a]) ||
                         (org[a] >= hi_e[a] && org[a] <= lo_e[a])))
        miss_d = 1'b1;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbst_div u_div_a (
      .clk_i (clk_i), .en_i (adv), .num_i (num_a[a]), .den_i (dir[a]), .quo_o (quo_a[a])
    );
    sbst_div u_div_b (
      .clk_i (clk_i), .en_i (adv), .num_i (num_b[a]), .den_i (dir[a]), .quo_o (quo_b[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  always_comb begin
    entry = sbst_pkg::SAT_LO;
    exitv = sbst_pkg::SAT_HI;
    for (int a = 0; a < 3; a++) begin
      if (en_q[a] > entry) entry = en_q[a];
      if (lv_q[a] < exitv) exitv = lv_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q[0] <= zero_d;
      miss_q[0] <= miss_d;
      for (int i = 1; i < DL; i++) begin
        zero_q[i] <= zero_q[i-1];
        miss_q[i] <= miss_q[i-1];
      end
      sa_q <= quo_a;
      sb_q <= quo_b;
      z1_q <= zero_q[DL-1];
      m1_q <= miss_q[DL-1];
      for (int a = 0; a < 3; a++) begin
        if (z1_q[a]) begin
          en_q[a] <= sbst_pkg::SAT_LO;
          lv_q[a] <= sbst_pkg::SAT_HI;
        end else if (sa_q[a] < sb_q[a]) begin
          en_q[a] <= sa_q[a];
          lv_q[a] <= sb_q[a];
        end else begin
          en_q[a] <= sb_q[a];
          lv_q[a] <= sa_q[a];
        end
      end
      m2_q  <= m1_q;
      hit_q <= !m2_q && (entry <= exitv) && (exitv >= 0) && (entry <= sbst_pkg::ONE);
    end
  end

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("stall_o does not follow the output stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |=> vld_q[0] == $past(valid_i))
    else $error("accepted request lost at pipeline entry");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule

/* bench/tb_segment_box_slab_test.sv */
`timescale 1ns / 100ps

module tb_segment_box_slab_test;

  typedef struct {
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    logic signed [31:0] org  [3];
    logic signed [31:0] dir  [3];
  } seg_box_t;

  // Predict the hit flag of one request.
  function automatic bit predict_hit(seg_box_t r);
    longint entry, leave, ta, tb, lo, hi, num;
    bit ok;
    entry = -64'sd2147483648;
    leave = 64'sd2147483647;
    ok = 1;
    for (int a = 0; a < 3; a++) begin
      if (r.dir[a] == 0) begin
        lo = (r.bmin[a] < r.bmax[a]) ? r.bmin[a] : r.bmax[a];
        hi = (r.bmin[a] < r.bmax[a]) ? r.bmax[a] : r.bmin[a];
        if (longint'(r.org[a]) < lo || longint'(r.org[a]) > hi) ok = 0;
      end else begin
        num = (longint'(r.bmin[a]) - longint'(r.org[a])) * 65536;
        ta = num / longint'(r.dir[a]);
        num = (longint'(r.bmax[a]) - longint'(r.org[a])) * 65536;
        tb = num / longint'(r.dir[a]);
        if (ta > 64'sd2147483647) ta = 64'sd2147483647;
        if (ta < -64'sd2147483648) ta = -64'sd2147483648;
        if (tb > 64'sd2147483647) tb = 64'sd2147483647;
        if (tb < -64'sd2147483648) tb = -64'sd2147483648;
        if (ta > tb) begin lo = tb; hi = ta; end else begin lo = ta; hi = tb; end
        if (lo > entry) entry = lo;
        if (hi < leave) leave = hi;
      end
    end
    return ok && entry <= leave && leave >= 0 && entry <= 65536;
  endfunction

  class hit_board;
    bit pending_hits[$];
    int errors;
    function void note_request(seg_box_t r);
      pending_hits.push_back(predict_hit(r));
    endfunction
    function void check_hit(logic h);
      bit e;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%b", h);
        return;
      end
      e = pending_hits.pop_front();
      if (h !== e) begin
        errors++;
        if (errors <= 10) $display("hit mismatch: expected %b actual %b", e, h);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic valid_i = 0, stall_i = 0;
  logic signed [31:0] bmin_x = 0, bmin_y = 0, bmin_z = 0, bmax_x = 0, bmax_y = 0, bmax_z = 0;
  logic signed [31:0] org_x = 0, org_y = 0, org_z = 0, dir_x = 0, dir_y = 0, dir_z = 0;
  logic stall_o, valid_o, hit_o;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int cycles = 0;
  hit_board board = new();

  always #1 clk_i = ~clk_i;

  segment_box_slab_test uut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .box_min_x_i(bmin_x), .box_min_y_i(bmin_y), .box_min_z_i(bmin_z),
    .box_max_x_i(bmax_x), .box_max_y_i(bmax_y), .box_max_z_i(bmax_z),
    .start_x_i(org_x), .start_y_i(org_y), .start_z_i(org_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .valid_o, .stall_i, .hit_o
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o && !stall_i) board.check_hit(hit_o);
    stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (cycles > 400000) begin
      $display("tb_segment_box_slab_test: errors");
      $finish;
    end
  end

  // Drive one request and hold it until accepted.
  task automatic send_request(seg_box_t r);
    seg_box_t cur;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 0;
      @(posedge clk_i);
    end
    valid_i <= 1;
    bmin_x <= r.bmin[0]; bmin_y <= r.bmin[1]; bmin_z <= r.bmin[2];
    bmax_x <= r.bmax[0]; bmax_y <= r.bmax[1]; bmax_z <= r.bmax[2];
    org_x <= r.org[0]; org_y <= r.org[1]; org_z <= r.org[2];
    dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
    cur = r;
    do @(posedge clk_i); while (stall_o);
    board.note_request(cur);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 0;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic seg_box_t random_request();
    seg_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.bmin[a] = pick_coord();
      r.bmax[a] = ($urandom_range(3) == 0) ? pick_coord() : r.bmin[a] + $urandom_range(1 << 18);
      r.org[a] = pick_coord();
      r.dir[a] = ($urandom_range(5) == 0) ? 0 : pick_coord();
    end
    return r;
  endfunction

  task automatic drain();
    valid_i <= 0;
    while (board.pending_hits.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    seg_box_t r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: unit box, extremes, zero directions, swapped corners, followed by random requests
    for (int k = 0; k < 20; k++) begin
      for (int a = 0; a < 3; a++) begin
        r.bmin[a] = 0; r.bmax[a] = 1 << 16; r.org[a] = -(1 << 16); r.dir[a] = 3 << 16;
      end
      case (k)
        1: r.dir[0] = 0;
        2: begin r.dir[1] = 0; r.org[1] = 1 << 15; end
        3: begin r.bmin[2] = 1 << 16; r.bmax[2] = 0; end
        4: r.dir[0] = 1;
        5: r.dir[0] = 32'sh80000000;
        6: r.dir[0] = 32'sh7fffffff;
        7: begin r.org[0] = 32'sh80000000; r.bmax[0] = 32'sh7fffffff; end
        8: begin r.dir[0] = -1; r.org[0] = 32'sh7fffffff; end
        9: begin r.dir = '{0, 0, 0}; r.org = '{0, 0, 0}; end
        10: begin r.dir = '{0, 0, 0}; r.org = '{0, 0, 32'sh7fffffff}; end
        11: begin r.dir = '{-1, -1, -1}; r.org = '{-1, -1, -1}; end
        12: r.org[0] = 2 << 16;
        13: begin r.bmin[1] = 32'sh80000000; r.bmax[1] = 32'sh7fffffff; end
        14: r.dir[2] = -(3 << 16);
        15: r.org = '{5 << 16, 5 << 16, 5 << 16};
        default: if (k > 15) r = random_request();
      endcase
      send_request(r);
    end
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 150; n++) send_request(random_request());
      drain();
    end
    recv_stall_pct = 0;
    repeat (sbst_pkg::LAT + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending_hits.size() == 0)
      $display("tb_segment_box_slab_test: clean");
    else
      $display("tb_segment_box_slab_test: errors");
    $finish;
  end
endmodule
